/* sv/srq_pkg.sv */
`timescale 1ns / 1ps
// srq_pkg: field widths, command and status codes and the entry type
// shared by the sorted run queue cells and top level. No dependencies.
package srq_pkg;

   localparam int KEY_W     = 32;
   localparam int ID_W      = 15;
   localparam int WT_W      = 17;
   localparam int SUM_W     = 22;
   localparam int CNT_W     = 6;
   localparam int DEPTH_DEF = 32;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_POP    = 1'b1;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [ID_W-1:0]  id;
      logic [WT_W-1:0]  weight;
   } entry_type;

   // broadcast to every cell in the row
   typedef struct packed {
      logic      ins;
      logic      pop;
      entry_type new_entry;
   } cell_ctrl_type;

endpackage

/* sv/srq_cell.sv */
`timescale 1ns / 1ps
// srq_cell: one slot of the sorted row. Holds one entry, flags whether a new
// key lands here or nearer the head, and shifts toward either neighbor. Uses srq_pkg.
module srq_cell (
   input  logic                  clock,
   input  srq_pkg::cell_ctrl_type ctrl,
   input  logic                  occupied,
   input  logic                  left_place,
   input  srq_pkg::entry_type    left_entry,
   input  srq_pkg::entry_type    right_entry,
   output logic                  place,
   output srq_pkg::entry_type    entry
);

   srq_pkg::entry_type entry_ff;
   srq_pkg::entry_type entry_in;

   // new key goes at or above this slot: empty, or stored key strictly larger
   assign place = !occupied ||
                  ($signed(entry_ff.key) > $signed(ctrl.new_entry.key));

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.ins && place) begin
         entry_in = left_place ? left_entry : ctrl.new_entry;
      end else if (ctrl.pop) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

/* sv/sorted_run_queue_unit.sv */
`timescale 1ns / 1ps
// sorted_run_queue_unit: top level of the sorted run queue, a row of
// srq_cell slots plus count, weight sum and result register. Uses srq_pkg.
//
//   channel | direction | tdata                           | tuser
//   --------+-----------+---------------------------------+---------------
//   req_    | in        | key, proc_id, entry_weight      | command
//   rsp_    | out       | popped_id, entry_count,         | status
//           |           | weight_sum, min_key             |
//
// One word per cycle while the response is not stalled: every cell compares
// its key with the incoming key at once and the whole row shifts together, so
// the row compare plus neighbor select is the critical path. The result is
// held in the output register from the cycle after its request word is taken.
// Reset clears the count, weight sum and output valid; slot contents are
// never read until written.
// A stalled result holds req_tready low only while rsp_tready is low.
module sorted_run_queue_unit #(
   parameter int DEPTH = srq_pkg::DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // key[31:0], proc_id[46:32], entry_weight[63:47]
   input  logic        req_tuser,   // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // popped_id[14:0], entry_count[20:15],
                                    // weight_sum[42:21], min_key[74:43], zero pad
   output logic [1:0]  rsp_tuser    // status
);

   localparam int FILL_W = $clog2(DEPTH + 1);

   // request fields
   srq_pkg::entry_type req_entry;
   logic               req_cmd;
   logic               req_fire;

   assign req_entry.key    = req_tdata[31:0];
   assign req_entry.id     = req_tdata[46:32];
   assign req_entry.weight = req_tdata[63:47];
   assign req_cmd          = req_tuser;

   // queue state
   logic [FILL_W-1:0]        fill_ff, fill_in;
   logic [srq_pkg::SUM_W-1:0] sum_ff, sum_in;

   logic is_full, is_empty;
   logic do_ins, do_pop;

   assign is_full  = (fill_ff == FILL_W'(DEPTH));
   assign is_empty = (fill_ff == '0);

   // output register
   logic                      rsp_valid_ff;
   srq_pkg::status_type       status_ff, status_in;
   logic [srq_pkg::ID_W-1:0]  popped_ff, popped_in;
   logic [srq_pkg::CNT_W-1:0] count_ff;
   logic [srq_pkg::SUM_W-1:0] rsum_ff;
   logic [srq_pkg::KEY_W-1:0] minkey_ff, minkey_in;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   assign do_ins = req_fire && (req_cmd == srq_pkg::CMD_INSERT) && !is_full;
   assign do_pop = req_fire && (req_cmd == srq_pkg::CMD_POP) && !is_empty;

   // cell row
   srq_pkg::cell_ctrl_type ctrl;
   srq_pkg::entry_type     cell_entry [DEPTH];
   logic [DEPTH-1:0]       cell_place;

   assign ctrl.ins       = do_ins;
   assign ctrl.pop       = do_pop;
   assign ctrl.new_entry = req_entry;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic               occ;
      logic               lplace;
      srq_pkg::entry_type lentry;
      srq_pkg::entry_type rentry;

      assign occ = (FILL_W'(i) < fill_ff);

      if (i == 0) begin : g_head
         assign lplace = 1'b0;
         assign lentry = req_entry;
      end else begin : g_body
         assign lplace = cell_place[i-1];
         assign lentry = cell_entry[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign rentry = cell_entry[i];
      end else begin : g_mid
         assign rentry = cell_entry[i+1];
      end

      srq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (occ),
         .left_place  (lplace),
         .left_entry  (lentry),
         .right_entry (rentry),
         .place       (cell_place[i]),
         .entry       (cell_entry[i])
      );
   end

   // count, weight sum and result fields
   always_comb begin
      fill_in   = fill_ff;
      sum_in    = sum_ff;
      status_in = srq_pkg::STAT_OK;
      popped_in = '0;
      minkey_in = '0;
      if (req_cmd == srq_pkg::CMD_INSERT) begin
         if (is_full) begin
            status_in = srq_pkg::STAT_FULL;
            minkey_in = cell_entry[0].key;
         end else begin
            fill_in   = fill_ff + FILL_W'(1);
            sum_in    = sum_ff + srq_pkg::SUM_W'(req_entry.weight);
            // new key becomes head when it is below the old head or queue is empty
            minkey_in = cell_place[0] ? req_entry.key : cell_entry[0].key;
         end
      end else begin
         if (is_empty) begin
            status_in = srq_pkg::STAT_EMPTY;
         end else begin
            fill_in   = fill_ff - FILL_W'(1);
            sum_in    = sum_ff - srq_pkg::SUM_W'(cell_entry[0].weight);
            popped_in = cell_entry[0].id;
            minkey_in = (fill_ff > FILL_W'(1)) ? cell_entry[1].key : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            fill_ff <= fill_in;
            sum_ff  <= sum_in;
         end
         if (req_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         status_ff <= status_in;
         popped_ff <= popped_in;
         count_ff  <= srq_pkg::CNT_W'(fill_in);
         rsum_ff   <= sum_in;
         minkey_ff <= minkey_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {5'd0, minkey_ff, rsum_ff, count_ff, popped_ff};

endmodule
